FILE: design/gsi_pkg.sv
package gsi_pkg;

  localparam int MAX_GEARS = 8;
  localparam int FRAC_BITS = 16;
  localparam int DW = 64;
  localparam int RATIO_FRAC = 12;
  localparam int COEF_W = 24;

  typedef logic signed [DW-1:0] word_t;

  localparam logic [1:0] REQ_STEP = 2'd0;
  localparam logic [1:0] REQ_UP   = 2'd1;
  localparam logic [1:0] REQ_DOWN = 2'd2;

  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_FRICTION  = 3'd1;
  localparam logic [2:0] REG_INERTIA   = 3'd2;
  localparam logic [2:0] REG_GEARS     = 3'd3;
  localparam logic [2:0] REG_RATIOS_LO = 3'd4;
  localparam logic [2:0] REG_RATIOS_HI = 3'd5;

  localparam logic [COEF_W-1:0] NEUTRAL_FRIC = COEF_W'(6554);
  localparam word_t NEUTRAL_INERTIA = word_t'(((64'sd1 <<< FRAC_BITS) + 5) / 10);
  localparam word_t ACC_LIM = word_t'(64'sd1 <<< 38);
  localparam word_t S32_MAX = word_t'(64'sd2147483647);
  localparam word_t S32_MIN = word_t'(-64'sd2147483648);

  function automatic word_t lim(input word_t x);
    if (x > ACC_LIM) return ACC_LIM;
    if (x < -ACC_LIM) return -ACC_LIM;
    return x;
  endfunction

  function automatic word_t sat32(input word_t x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  function automatic logic out32(input word_t x);
    return (x > S32_MAX) || (x < S32_MIN);
  endfunction

endpackage

FILE: design/gsi_if.sv
interface gsi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] engine_torque;
  logic [31:0] load_torque;
  modport source (output valid, req_type, engine_torque, load_torque, input ready);
  modport sink (input valid, req_type, engine_torque, load_torque, output ready);
endinterface

interface gsi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] input_speed;
  logic [31:0] output_speed;
  logic [2:0]  gear_index;
  logic        saturated;
  modport source (output valid, input_speed, output_speed, gear_index, saturated,
                  input ready);
  modport sink (input valid, input_speed, output_speed, gear_index, saturated,
                output ready);
endinterface

interface gsi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/gearbox_shaft_integrator_unit.sv
// gearbox shaft integrator: one result word per input word, one word in flight
// shift word: S_DONE registers the result once the output is free; a physics word
// first runs the sequencer through the shared bit-serial multiplier
// and the bit-serial divider, twice over in neutral
// next word accepted in the cycle after the result is registered; a full output holds it
// reset (rst, synchronous): speeds and gear cleared, registers to defaults
module gearbox_shaft_integrator_unit import gsi_pkg::*; (
  input logic clk,
  input logic rst,
  gsi_in_if.sink   in_ch,
  gsi_out_if.source out_ch,
  gsi_cfg_if.sink  cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_TDIV, S_M1, S_D1, S_M2, S_M3, S_D2, S_M4, S_ODIV, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] time_step;
  logic [23:0] friction_coeff;
  logic [31:0] shaft_inertia;
  logic [3:0]  gear_count;
  logic [63:0] ratios_low, ratios_high;

  // shaft state
  word_t in_speed, out_speed;
  logic [2:0] gear;

  // working registers of the sequencer
  word_t tl, tq, v, a1, inert;
  logic [COEF_W-1:0] fric;
  logic signed [15:0] ratio;
  logic pass_out, sat;

  // shared serial units
  logic mul_go, mul_done, div_go, div_done;
  logic [COEF_W-1:0] mul_b;
  word_t mul_a, mul_p, div_n, div_d, div_q;

  gsi_mul u_mul (.clk, .rst, .start(mul_go), .a(mul_a), .b(mul_b),
                 .done(mul_done), .p(mul_p));
  gsi_div u_div (.clk, .rst, .start(div_go), .n(div_n), .d(div_d),
                 .done(div_done), .q(div_q));

  logic [127:0] ratios_all;
  logic signed [15:0] ratio_sel;
  logic [2:0] top;
  word_t te_x, tl_x, inert_x, num, vp, ssum, heun_res, heun_sat;

  assign ratios_all = {ratios_high, ratios_low};
  assign ratio_sel  = ratios_all[{gear, 4'b0000} +: 16];
  assign top = (gear_count == 4'd0) ? 3'd0 :
               (gear_count > 4'(MAX_GEARS)) ? 3'(MAX_GEARS - 1) : 3'(gear_count - 4'd1);
  assign te_x = word_t'($signed(in_ch.engine_torque));
  assign tl_x = word_t'($signed(in_ch.load_torque));
  assign inert_x = (shaft_inertia == 32'd0) ? word_t'(1) : word_t'({32'd0, shaft_inertia});

  // products rescale by arithmetic shift, which floors
  assign num      = lim(tq - (mul_p >>> 16));
  assign vp       = lim(v + (mul_p >>> 16));
  assign ssum     = lim(a1 + lim(div_q));
  assign heun_res = v + (mul_p >>> 17);
  assign heun_sat = sat32(heun_res);

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      time_step      <= 16'd655;
      friction_coeff <= 24'd655;
      shaft_inertia  <= 32'd65536;
      gear_count     <= 4'd1;
      ratios_low     <= '0;
      ratios_high    <= '0;
      in_speed       <= '0;
      out_speed      <= '0;
      gear           <= '0;
      mul_go         <= 1'b0;
      div_go         <= 1'b0;
      out_ch.valid   <= 1'b0;
      pass_out       <= 1'b0;
      sat            <= 1'b0;
    end else begin
      mul_go <= 1'b0;
      div_go <= 1'b0;
      // the result state reloads the output itself
      if (out_ch.valid && out_ch.ready && state != S_DONE) out_ch.valid <= 1'b0;

      if (cfg.valid) begin
        case (cfg.index)
          REG_TIME_STEP: time_step      <= cfg.data[15:0];
          REG_FRICTION:  friction_coeff <= cfg.data[23:0];
          REG_INERTIA:   shaft_inertia  <= cfg.data[31:0];
          REG_GEARS:     gear_count     <= cfg.data[3:0];
          REG_RATIOS_LO: ratios_low     <= cfg.data;
          REG_RATIOS_HI: ratios_high    <= cfg.data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            sat      <= 1'b0;
            pass_out <= 1'b0;
            tl       <= tl_x;
            ratio    <= ratio_sel;
            fric     <= friction_coeff;
            inert    <= inert_x;
            v        <= in_speed;
            case (in_ch.req_type)
              REQ_STEP: begin
                if (ratio_sel != 16'sd0) begin
                  // load torque reflected through the ratio
                  tq     <= te_x;
                  div_n  <= tl_x <<< RATIO_FRAC;
                  div_d  <= word_t'(ratio_sel);
                  div_go <= 1'b1;
                  state  <= S_TDIV;
                end else begin
                  tq     <= lim(te_x);
                  mul_a  <= in_speed;
                  mul_b  <= friction_coeff;
                  mul_go <= 1'b1;
                  state  <= S_M1;
                end
              end
              REQ_UP: begin
                gear  <= (gear >= top) ? top : gear + 3'd1;
                state <= S_DONE;
              end
              REQ_DOWN: begin
                if (gear != 3'd0) gear <= gear - 3'd1;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_TDIV: if (div_done) begin
          tq     <= lim(tq + div_q);
          mul_a  <= v;
          mul_b  <= fric;
          mul_go <= 1'b1;
          state  <= S_M1;
        end
        // friction product -> first acceleration
        S_M1: if (mul_done) begin
          div_n  <= num <<< FRAC_BITS;
          div_d  <= inert;
          div_go <= 1'b1;
          state  <= S_D1;
        end
        S_D1: if (div_done) begin
          a1     <= lim(div_q);
          mul_a  <= lim(div_q);
          mul_b  <= COEF_W'(time_step);
          mul_go <= 1'b1;
          state  <= S_M2;
        end
        // predicted speed
        S_M2: if (mul_done) begin
          mul_a  <= vp;
          mul_b  <= fric;
          mul_go <= 1'b1;
          state  <= S_M3;
        end
        S_M3: if (mul_done) begin
          div_n  <= num <<< FRAC_BITS;
          div_d  <= inert;
          div_go <= 1'b1;
          state  <= S_D2;
        end
        // average of both accelerations times dt
        S_D2: if (div_done) begin
          mul_a  <= ssum;
          mul_b  <= COEF_W'(time_step);
          mul_go <= 1'b1;
          state  <= S_M4;
        end
        S_M4: if (mul_done) begin
          if (out32(heun_res)) sat <= 1'b1;
          if (!pass_out) begin
            in_speed <= heun_sat;
            if (ratio != 16'sd0) begin
              div_n  <= heun_sat <<< RATIO_FRAC;
              div_d  <= word_t'(ratio);
              div_go <= 1'b1;
              state  <= S_ODIV;
            end else begin
              // neutral: output shaft integrates on its own
              pass_out <= 1'b1;
              v        <= out_speed;
              tq       <= lim(tl);
              fric     <= NEUTRAL_FRIC;
              inert    <= NEUTRAL_INERTIA;
              mul_a    <= out_speed;
              mul_b    <= NEUTRAL_FRIC;
              mul_go   <= 1'b1;
              state    <= S_M1;
            end
          end else begin
            out_speed <= heun_sat;
            state     <= S_DONE;
          end
        end
        S_ODIV: if (div_done) begin
          out_speed <= sat32(div_q);
          if (out32(div_q)) sat <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: if (!out_ch.valid || out_ch.ready) begin
          out_ch.valid        <= 1'b1;
          out_ch.input_speed  <= in_speed[31:0];
          out_ch.output_speed <= out_speed[31:0];
          out_ch.gear_index   <= gear;
          out_ch.saturated    <= sat;
          state               <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/gsi_mul.sv
module gsi_mul import gsi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  word_t             a,
  input  logic [COEF_W-1:0] b,
  output logic              done,
  output word_t             p
);
  // shift-add, one multiplier bit per cycle
  word_t acc, ash;
  logic [COEF_W-1:0] bsh;
  logic [$clog2(COEF_W)-1:0] cnt;
  logic busy;

  assign p = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= '0;
        ash  <= a;
        bsh  <= b;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (bsh[0]) acc <= acc + ash;
        ash <= ash <<< 1;
        bsh <= bsh >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(COEF_W))'(COEF_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: design/gsi_div.sv
module gsi_div import gsi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t n,
  input  word_t d,
  output logic  done,
  output word_t q
);
  // restoring division on magnitudes, one quotient bit per cycle
  logic [DW:0] rem;
  logic [DW:0] trial;
  logic [DW-1:0] qsh, dm;
  logic [$clog2(DW)-1:0] cnt;
  logic neg, busy;

  assign trial = {rem[DW-1:0], qsh[DW-1]};
  assign q = neg ? -word_t'(qsh) : word_t'(qsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg  <= n[DW-1] ^ d[DW-1];
        qsh  <= n[DW-1] ? DW'(-n) : DW'(n);
        dm   <= d[DW-1] ? DW'(-d) : DW'(d);
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, dm}) begin
          rem <= trial - {1'b0, dm};
          qsh <= {qsh[DW-2:0], 1'b1};
        end else begin
          rem <= trial;
          qsh <= {qsh[DW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(DW))'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: sim/gsi_tb_if.sv
`timescale 1ns / 1ps

// bundles of the three channels live in the design interfaces; this file
// holds the testbench-side word types shared by driver and monitor
package gsi_tb_pkg;
  import gsi_pkg::*;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] eng;
    logic [31:0] load;
    int          gap;
    bit          drain;
  } cmd_word_t;

  typedef struct {
    logic [31:0] in_spd;
    logic [31:0] out_spd;
    logic [2:0]  gear;
    logic        sat;
  } speed_word_t;
endpackage

FILE: sim/gearbox_shaft_integrator_unit_test.sv
`timescale 1ns / 1ps

module gearbox_shaft_integrator_unit_test;
  import gsi_pkg::*;
  import gsi_tb_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int SETTLE = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  gsi_in_if  in_ch ();
  gsi_out_if out_ch ();
  gsi_cfg_if cfg ();

  gearbox_shaft_integrator_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  // shadow copy of the block's registers and shaft state
  logic [15:0] dt_q;
  logic [23:0] fric_q;
  logic [31:0] inert_q;
  logic [3:0]  ngear_q;
  logic [63:0] rlo_q, rhi_q;
  longint      in_spd_q, out_spd_q;
  int unsigned gear_q;

  cmd_word_t   cmd_q[$];
  speed_word_t speed_q[$];

  int mismatches = 0;
  int accepted_in = 0;
  int accepted_out = 0;
  int n_sat = 0;
  int n_neutral = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  int in_gap = 0;
  int out_wait = 0;
  bit drain_hold = 0;
  // configuration writes, issued only while no word is in flight
  bit cfg_busy = 0;
  // handshakes seen at the last rising edge
  bit in_fire = 0;
  bit out_fire = 0;

  localparam longint LIM38 = 64'sd1 <<< 38;

  function automatic longint clip38(longint x);
    if (x > LIM38) return LIM38;
    if (x < -LIM38) return -LIM38;
    return x;
  endfunction

  // rescale with rounding toward minus infinity
  function automatic longint shr_floor(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint shaft_accel(longint t, longint f, longint v, longint j);
    longint num;
    num = clip38(t - shr_floor(f * v, 16));
    return clip38((num * 65536) / j);
  endfunction

  // improved euler step, not yet clamped to 32 bits
  function automatic longint heun_speed(longint v, longint t, longint f, longint j,
                                        longint h);
    longint a1, a2, vp, s;
    a1 = shaft_accel(t, f, v, j);
    vp = clip38(v + shr_floor(a1 * h, 16));
    a2 = shaft_accel(t, f, vp, j);
    s = clip38(a1 + a2);
    return v + shr_floor(s * h, 17);
  endfunction

  function automatic longint clamp32(longint x, ref bit flag);
    if (x > 64'sd2147483647) begin flag = 1; return 64'sd2147483647; end
    if (x < -64'sd2147483648) begin flag = 1; return -64'sd2147483648; end
    return x;
  endfunction

  function automatic longint ratio_of(int unsigned g);
    logic [63:0] r;
    r = (g < 4) ? rlo_q : rhi_q;
    return longint'($signed(r[16*(g%4) +: 16]));
  endfunction

  // predict the speed word for one accepted command word
  task automatic predict_speeds(cmd_word_t c);
    speed_word_t e;
    bit sat;
    longint r, tsum, te, tl, j;
    int unsigned top;
    sat = 0;
    if (c.req == REQ_STEP) begin
      te = longint'($signed(c.eng));
      tl = longint'($signed(c.load));
      r = ratio_of(gear_q);
      j = (inert_q == 0) ? 1 : longint'(inert_q);
      tsum = (r != 0) ? clip38(te + (tl * 4096) / r) : clip38(te);
      in_spd_q = clamp32(heun_speed(in_spd_q, tsum, longint'(fric_q), j,
                                    longint'(dt_q)), sat);
      if (r != 0) out_spd_q = clamp32((in_spd_q * 4096) / r, sat);
      else begin
        n_neutral++;
        out_spd_q = clamp32(heun_speed(out_spd_q, clip38(tl), 6554,
                                       (65536 + 5) / 10, longint'(dt_q)), sat);
      end
    end else if (c.req == REQ_UP) begin
      top = (ngear_q == 0) ? 0 : (ngear_q > MAX_GEARS ? MAX_GEARS - 1 : ngear_q - 1);
      gear_q = (gear_q >= top) ? top : gear_q + 1;
    end else if (c.req == REQ_DOWN) begin
      if (gear_q > 0) gear_q--;
    end
    e.in_spd = in_spd_q[31:0];
    e.out_spd = out_spd_q[31:0];
    e.gear = gear_q[2:0];
    e.sat = sat;
    if (sat) n_sat++;
    speed_q.push_back(e);
  endtask

  // driver: command words go out at the falling edge after a random gap
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_fire) begin
      // accepted at the last rising edge; the monitor already predicted it
      in_ch.valid <= 1'b0;
      in_gap <= cmd_q.size() ? cmd_q[0].gap : 0;
    end else if (in_ch.valid) begin
      // hold the word until accepted
    end else if (drain_hold) begin
      if (speed_q.size() == 0) drain_hold <= 0;
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
    end else if (cmd_q.size() != 0 && !cfg_busy) begin
      if (cmd_q[0].drain) begin
        drain_hold <= 1;
        cmd_q[0].drain = 0;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.req_type <= cmd_q[0].req;
        in_ch.engine_torque <= cmd_q[0].eng;
        in_ch.load_torque <= cmd_q[0].load;
      end
    end
  end

  // output side stall, redrawn after each accepted word
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_wait <= $urandom_range(0, 17);
    end else if (out_fire) begin
      out_ch.ready <= 1'b0;
      out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    speed_word_t e;
    in_fire <= !rst && in_ch.valid && in_ch.ready;
    out_fire <= !rst && out_ch.valid && out_ch.ready;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_speeds(cmd_q.pop_front());
        accepted_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        accepted_out++;
        if (speed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected speed word at %0t", $realtime);
        end else begin
          e = speed_q.pop_front();
          if (out_ch.input_speed !== e.in_spd || out_ch.output_speed !== e.out_spd ||
              out_ch.gear_index !== e.gear || out_ch.saturated !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: exp in=%h out=%h gear=%0d sat=%0b, got in=%h out=%h gear=%0d sat=%0b",
                       $realtime, e.in_spd, e.out_spd, e.gear, e.sat,
                       out_ch.input_speed, out_ch.output_speed,
                       out_ch.gear_index, out_ch.saturated);
          end
        end
      end
      // watchdog on cycles with no handshake at all
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg.valid && cfg.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("watchdog: no traffic for %0d cycles", WATCHDOG);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_busy = 1;
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_TIME_STEP: dt_q = val[15:0];
      REG_FRICTION:  fric_q = val[23:0];
      REG_INERTIA:   inert_q = val[31:0];
      REG_GEARS:     ngear_q = val[3:0];
      REG_RATIOS_LO: rlo_q = val;
      REG_RATIOS_HI: rhi_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
    cfg_busy = 0;
  endtask

  // wait until the block has delivered every expected word and gone quiet
  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_ch.valid || speed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_torque();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [15:0] rand_ratio();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'h8000;
      3: return 16'hffff;
      4: return 16'($urandom());
      default: return 16'($signed($urandom_range(512, 16384)) *
                          ($urandom_range(0, 1) ? 1 : -1));
    endcase
  endfunction

  task automatic push_cmd(logic [1:0] r, logic [31:0] e, logic [31:0] l, bit d = 0);
    cmd_word_t c;
    c.req = r;
    c.eng = e;
    c.load = l;
    c.drain = d;
    c.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    cmd_q.push_back(c);
  endtask

  // one random phase: random settings, then a run of mostly physics words
  task automatic random_phase(int n);
    write_reg(REG_TIME_STEP, ($urandom_range(0, 9) == 0) ? 64'hffff : $urandom_range(0, 4000));
    write_reg(REG_FRICTION, ($urandom_range(0, 9) == 0) ? 64'hffffff : $urandom_range(0, 20000));
    write_reg(REG_INERTIA, ($urandom_range(0, 9) == 0) ? 64'(32'($urandom())) :
              $urandom_range(0, 1 << 18));
    write_reg(REG_GEARS, $urandom_range(0, 15));
    write_reg(REG_RATIOS_LO, {rand_ratio(), rand_ratio(), rand_ratio(), rand_ratio()});
    write_reg(REG_RATIOS_HI, {rand_ratio(), rand_ratio(), rand_ratio(), rand_ratio()});
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: push_cmd(REQ_UP, $urandom(), $urandom());
        1: push_cmd(REQ_DOWN, $urandom(), $urandom());
        2: push_cmd(2'd3, $urandom(), $urandom());
        default: push_cmd(REQ_STEP, rand_torque(), rand_torque(), i == n / 2);
      endcase
    end
    wait_idle();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_STEP;
    in_ch.engine_torque = '0;
    in_ch.load_torque = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_TIME_STEP;
    cfg.data = '0;
    dt_q = 16'd655;
    fric_q = 24'd655;
    inert_q = 32'd65536;
    ngear_q = 4'd1;
    rlo_q = '0;
    rhi_q = '0;
    in_spd_q = 0;
    out_spd_q = 0;
    gear_q = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset defaults, neutral, extreme torques, unused code
    push_cmd(REQ_STEP, 32'h00010000, 32'h00010000);
    push_cmd(REQ_STEP, 32'h7fffffff, 32'h80000000);
    push_cmd(REQ_STEP, 32'h80000000, 32'h7fffffff);
    push_cmd(REQ_UP, 32'hffffffff, 32'hffffffff);
    push_cmd(REQ_DOWN, 32'h0, 32'h0);
    push_cmd(2'd3, 32'h0, 32'h0);
    wait_idle();

    // directed: full gear table, zero inertia, max step, shifting past the top gear
    write_reg(REG_TIME_STEP, 64'hffff);
    write_reg(REG_FRICTION, 64'h0);
    write_reg(REG_INERTIA, 64'h0);
    write_reg(REG_GEARS, 64'd8);
    write_reg(REG_RATIOS_LO, {16'h8000, 16'h7fff, 16'hf000, 16'h1000});
    write_reg(REG_RATIOS_HI, {16'h0001, 16'hffff, 16'h0000, 16'h0800});
    for (int g = 0; g < 9; g++) begin
      push_cmd(REQ_STEP, 32'h7fffffff, 32'h80000000);
      push_cmd(REQ_UP, 32'h0, 32'h0);
    end
    push_cmd(REQ_STEP, 32'h80000000, 32'h7fffffff);
    wait_idle();

    // lowering the gear count while above it, then shifting up and down
    write_reg(REG_GEARS, 64'd3);
    write_reg(REG_FRICTION, 64'hffffff);
    write_reg(REG_INERTIA, 64'hffffffff);
    push_cmd(REQ_UP, 32'h0, 32'h0);
    for (int g = 0; g < 4; g++) push_cmd(REQ_DOWN, 32'h0, 32'h0);
    push_cmd(REQ_STEP, 32'h12345678, 32'hedcba987);
    wait_idle();
    write_reg(REG_GEARS, 64'd0);
    push_cmd(REQ_UP, 32'h0, 32'h0);
    wait_idle();
    write_reg(REG_GEARS, 64'd15);
    wait_idle();

    for (int p = 0; p < 16; p++) random_phase(100);

    wait_idle();
    $display("covered %0d command words, %0d speed words, %0d neutral steps, %0d clamped",
             accepted_in, accepted_out, n_neutral, n_sat);
    $display("settings cycled across 16 random phases plus register extremes");
    if (mismatches == 0 && speed_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d words still expected", mismatches, speed_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
